@@ rtl/core/ati_pkg.sv @@
package ati_pkg;

  localparam int unsigned StdLen = 38;
  localparam int unsigned HeLen  = 36;

  localparam logic [40:0] EtwQ47   = 41'd1744933749374;
  localparam logic [29:0] ScaleAir = 30'd517544;
  localparam logic [29:0] ScaleSi  = 30'd1000727380;
  localparam logic [29:0] ScaleHe  = 30'd76665;

  localparam logic [1:0] MatAir  = 2'd0;
  localparam logic [1:0] MatSi   = 2'd1;
  localparam logic [1:0] MatHe   = 2'd2;
  localparam logic [1:0] MatNone = 2'd3;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DIV1   = 8'b0000_0010,
    S_SEARCH = 8'b0000_0100,
    S_MUL1   = 8'b0000_1000,
    S_MUL2   = 8'b0001_0000,
    S_DIV2   = 8'b0010_0000,
    S_SCALE  = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  function automatic logic [31:0] std_energy(input logic [5:0] i);
    case (i)
      6'd0: return 32'd134218;      6'd1: return 32'd201327;
      6'd2: return 32'd268435;      6'd3: return 32'd402653;
      6'd4: return 32'd429886;      6'd5: return 32'd429886;
      6'd6: return 32'd536871;      6'd7: return 32'd671089;
      6'd8: return 32'd805306;      6'd9: return 32'd1073742;
      6'd10: return 32'd1342177;    6'd11: return 32'd2013266;
      6'd12: return 32'd2684355;    6'd13: return 32'd4026532;
      6'd14: return 32'd5368709;    6'd15: return 32'd6710886;
      6'd16: return 32'd8053064;    6'd17: return 32'd10737418;
      6'd18: return 32'd13421773;   6'd19: return 32'd20132659;
      6'd20: return 32'd26843546;   6'd21: return 32'd40265318;
      6'd22: return 32'd53687091;   6'd23: return 32'd67108864;
      6'd24: return 32'd80530637;   6'd25: return 32'd107374182;
      6'd26: return 32'd134217728;  6'd27: return 32'd167772160;
      6'd28: return 32'd201326592;  6'd29: return 32'd268435456;
      6'd30: return 32'd402653184;  6'd31: return 32'd536870912;
      6'd32: return 32'd671088640;  6'd33: return 32'd805306368;
      6'd34: return 32'd1073741824; 6'd35: return 32'd1342177280;
      6'd36: return 32'd2013265920; 6'd37: return 32'd2684354560;
      default: return 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] std_atten(input logic [5:0] i);
    case (i)
      6'd0: return 32'd3781165056;  6'd1: return 32'd1248854016;
      6'd2: return 32'd553543270;   6'd3: return 32'd170393600;
      6'd4: return 32'd140509184;   6'd5: return 32'd155713536;
      6'd6: return 32'd81663099;    6'd7: return 32'd42226156;
      6'd8: return 32'd24547164;    6'd9: return 32'd10402922;
      6'd10: return 32'd5368709;    6'd11: return 32'd1692402;
      6'd12: return 32'd815687;     6'd13: return 32'd370986;
      6'd14: return 32'd260571;     6'd15: return 32'd218104;
      6'd16: return 32'd196608;     6'd17: return 32'd174273;
      6'd18: return 32'd161586;     6'd19: return 32'd142187;
      6'd20: return 32'd129289;     6'd21: return 32'd111883;
      6'd22: return 32'd100129;     6'd23: return 32'd91352;
      6'd24: return 32'd84463;      6'd25: return 32'd74176;
      6'd26: return 32'd66668;      6'd27: return 32'd59633;
      6'd28: return 32'd54264;      6'd29: return 32'd46630;
      6'd30: return 32'd37550;      6'd31: return 32'd32286;
      6'd32: return 32'd28846;      6'd33: return 32'd26445;
      6'd34: return 32'd23331;      6'd35: return 32'd21443;
      6'd36: return 32'd18979;      6'd37: return 32'd17878;
      default: return 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] he_energy(input logic [5:0] i);
    case (i)
      6'd0: return 32'd134218;      6'd1: return 32'd201327;
      6'd2: return 32'd268435;      6'd3: return 32'd402653;
      6'd4: return 32'd536871;      6'd5: return 32'd671089;
      6'd6: return 32'd805306;      6'd7: return 32'd1073742;
      6'd8: return 32'd1342177;     6'd9: return 32'd2013266;
      6'd10: return 32'd2684355;    6'd11: return 32'd4026532;
      6'd12: return 32'd5368709;    6'd13: return 32'd6710886;
      6'd14: return 32'd8053064;    6'd15: return 32'd10737418;
      6'd16: return 32'd13421773;   6'd17: return 32'd20132659;
      6'd18: return 32'd26843546;   6'd19: return 32'd40265318;
      6'd20: return 32'd53687091;   6'd21: return 32'd67108864;
      6'd22: return 32'd80530637;   6'd23: return 32'd107374182;
      6'd24: return 32'd134217728;  6'd25: return 32'd167772160;
      6'd26: return 32'd201326592;  6'd27: return 32'd268435456;
      6'd28: return 32'd402653184;  6'd29: return 32'd536870912;
      6'd30: return 32'd671088640;  6'd31: return 32'd805306368;
      6'd32: return 32'd1073741824; 6'd33: return 32'd1342177280;
      6'd34: return 32'd2013265920; 6'd35: return 32'd2684354560;
      default: return 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] he_atten(input logic [5:0] i);
    case (i)
      6'd0: return 32'd63795364;    6'd1: return 32'd17574134;
      6'd2: return 32'd7196377;     6'd3: return 32'd2104492;
      6'd4: return 32'd978217;      6'd5: return 32'd604609;
      6'd6: return 32'd439878;      6'd7: return 32'd307547;
      6'd8: return 32'd259627;      6'd9: return 32'd219362;
      6'd10: return 32'd205521;     6'd11: return 32'd192728;
      6'd12: return 32'd184864;     6'd13: return 32'd178572;
      6'd14: return 32'd173120;     6'd15: return 32'd163788;
      6'd16: return 32'd155818;     6'd17: return 32'd140090;
      6'd18: return 32'd128346;     6'd19: return 32'd111568;
      6'd20: return 32'd99982;      6'd21: return 32'd91300;
      6'd22: return 32'd84452;      6'd23: return 32'd74197;
      6'd24: return 32'd66710;      6'd25: return 32'd59643;
      6'd26: return 32'd54243;      6'd27: return 32'd46368;
      6'd28: return 32'd36732;      6'd29: return 32'd30923;
      6'd30: return 32'd27022;      6'd31: return 32'd24191;
      6'd32: return 32'd20342;      6'd33: return 32'd17857;
      6'd34: return 32'd14292;      6'd35: return 32'd12405;
      default: return 32'd0;
    endcase
  endfunction

endpackage

@@ rtl/core/attenuation_table_interpolator.sv @@
// Channel | Signals                        | Direction
// input   | valid_in/ready_in, wavelength  | in
// result  | valid_out/ready_out,           | out
//         |   coefficient, out_of_range    |
// config  | cfg_we, cfg_data               | in
//
// One item at a time. A shared restoring divide stage resolves one quotient
// bit per cycle, for the energy and then for the interpolation divide.
// Table search visits up to 38 entries. When interpolating, the search is
// followed by S_MUL1, S_DIV2, S_SCALE, S_OUT and S_MUL2, which makes the
// result valid; on the first entry or a duplicate energy the search goes
// straight to S_SCALE; outside the table the search itself makes it valid,
// and the accept edge does so on zero wavelength or the unused material code.
// Synchronous reset clears control and material_select. A stalled result
// holds in the output register; the input side is not ready until it leaves.
module attenuation_table_interpolator (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid_in,
  output logic        ready_in,
  input  logic [23:0] wavelength,
  output logic        valid_out,
  input  logic        ready_out,
  output logic [31:0] coefficient,
  output logic        out_of_range,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data
);
  import ati_pkg::*;

  state_t      state;
  logic [1:0]  material_select;
  logic [63:0] num;       // dividend, shifted out MSB first
  logic [63:0] den;
  logic [63:0] quo;
  logic [64:0] rem;
  logic [6:0]  cnt;
  logic [5:0]  idx;
  logic [63:0] prod_a, prod_b;

  logic        he;
  logic [5:0]  last;
  logic [31:0] en_r, en_l, at_r, at_l;
  logic [64:0] rem_sh;
  logic [63:0] interp_prod;
  logic [29:0] scale;

  assign he   = (material_select == MatHe);
  assign last = he ? 6'(HeLen - 1) : 6'(StdLen - 1);
  assign en_r = he ? he_energy(idx) : std_energy(idx);
  assign at_r = he ? he_atten(idx) : std_atten(idx);
  assign en_l = he ? he_energy(idx - 6'd1) : std_energy(idx - 6'd1);
  assign at_l = he ? he_atten(idx - 6'd1) : std_atten(idx - 6'd1);

  always_comb begin
    case (material_select)
      MatAir:  scale = ScaleAir;
      MatSi:   scale = ScaleSi;
      default: scale = ScaleHe;
    endcase
  end

  // one restoring divide step per cycle
  assign rem_sh = {rem[63:0], num[63]};

  assign ready_in = (state == S_IDLE) && !valid_out;
  assign interp_prod = {32'd0, quo[31:0]} * {34'd0, scale};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      material_select <= MatAir;
      valid_out <= 1'b0;
    end else begin
      if (cfg_we) material_select <= cfg_data;
      if (valid_out && ready_out) valid_out <= 1'b0;
      case (state)
        S_IDLE: begin
          if (valid_in && ready_in) begin
            if (wavelength == 24'd0 || material_select == MatNone) begin
              coefficient <= 32'd0;
              out_of_range <= 1'b1;
              valid_out <= 1'b1;
            end else begin
              num <= {EtwQ47, 23'd0};
              den <= {40'd0, wavelength};
              rem <= '0;
              quo <= '0;
              cnt <= 7'd40;
              state <= S_DIV1;
            end
          end
        end
        S_DIV1: begin
          num <= num << 1;
          if (rem_sh >= {1'b0, den}) begin
            rem <= rem_sh - {1'b0, den};
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[62:0], 1'b0};
          end
          if (cnt == 7'd0) state <= S_SEARCH;
          cnt <= cnt - 7'd1;
          idx <= '0;
        end
        S_SEARCH: begin
          if (idx == 6'd0 && (quo[40:32] != 9'd0 || quo[31:0] < en_r ||
              quo[31:0] > (he ? he_energy(last) : std_energy(last)))) begin
            coefficient <= 32'd0;
            out_of_range <= 1'b1;
            valid_out <= 1'b1;
            state <= S_IDLE;
          end else if (idx < last && en_r < quo[31:0]) begin
            idx <= idx + 6'd1;
          end else if (idx == 6'd0) begin
            quo <= {32'd0, at_r};
            state <= S_SCALE;
          end else if (en_r == en_l) begin
            quo <= {32'd0, at_l};
            state <= S_SCALE;
          end else begin
            prod_a <= {32'd0, at_r} * {32'd0, quo[31:0] - en_l};
            prod_b <= {32'd0, at_l} * {32'd0, en_r - quo[31:0]};
            den <= {32'd0, en_r - en_l};
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          num <= prod_a + prod_b;
          rem <= '0;
          quo <= '0;
          cnt <= 7'd63;
          state <= S_DIV2;
        end
        S_DIV2: begin
          num <= num << 1;
          if (rem_sh >= {1'b0, den}) begin
            rem <= rem_sh - {1'b0, den};
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[62:0], 1'b0};
          end
          if (cnt == 7'd0) state <= S_SCALE;
          cnt <= cnt - 7'd1;
        end
        S_SCALE: begin
          prod_a <= interp_prod;
          state <= S_OUT;
        end
        S_OUT: begin
          prod_b <= prod_a + 64'h2000_0000;
          state <= S_MUL2;
        end
        S_MUL2: begin
          coefficient <= (prod_b[63:62] != 2'd0) ? 32'hFFFF_FFFF : prod_b[61:30];
          out_of_range <= 1'b0;
          valid_out <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/core/ati_checker.sv @@
module ati_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid_in,
  input logic        ready_in,
  input logic        valid_out,
  input logic        ready_out,
  input logic [31:0] coefficient,
  input logic        out_of_range
);
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    valid_out && out_of_range |-> coefficient == 32'd0) else $error("oor coef");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid_out && !ready_out |=> valid_out && $stable(coefficient)) else $error("hold");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    valid_out |-> !ready_in) else $error("busy");
  a_take: assert property (@(posedge clk) disable iff (rst)
    valid_in && ready_in |=> !ready_in) else $error("take");
endmodule

bind attenuation_table_interpolator ati_checker u_chk (.*);

@@ tb/attenuation_table_interpolator_tb.sv @@
`timescale 1ns / 1ps

module attenuation_table_interpolator_tb;
  import ati_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 200;

  typedef struct packed {
    logic [31:0] coefficient;
    logic        out_of_range;
  } absorption_t;

  // One row of the directed table. check_lit selects the typed-in result
  // over the predicted one.
  typedef struct {
    logic [23:0] wl;
    logic        check_lit;
    absorption_t lit;
  } directed_row_t;

  logic        clk;
  logic        rst;
  logic        valid_in;
  logic        ready_in;
  logic [23:0] wavelength;
  logic        valid_out;
  logic        ready_out;
  logic [31:0] coefficient;
  logic        out_of_range;
  logic        cfg_we;
  logic [1:0]  cfg_data;

  absorption_t pending_absorption[$];
  logic [1:0]  material;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned quiet_cycles;
  bit          failed;
  bit          driving_in;

  attenuation_table_interpolator uut (
    .clk         (clk),
    .rst         (rst),
    .valid_in    (valid_in),
    .ready_in    (ready_in),
    .wavelength  (wavelength),
    .valid_out   (valid_out),
    .ready_out   (ready_out),
    .coefficient (coefficient),
    .out_of_range(out_of_range),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Table entries, written out here so the predictor stands apart from the
  // package functions.
  localparam logic [31:0] StdEnergyTab [StdLen] = '{
    134218, 201327, 268435, 402653, 429886, 429886, 536871, 671089,
    805306, 1073742, 1342177, 2013266, 2684355, 4026532, 5368709,
    6710886, 8053064, 10737418, 13421773, 20132659, 26843546,
    40265318, 53687091, 67108864, 80530637, 107374182, 134217728,
    167772160, 201326592, 268435456, 402653184, 536870912, 671088640,
    805306368, 1073741824, 1342177280, 2013265920, 32'd2684354560};
  localparam logic [31:0] StdAttenTab [StdLen] = '{
    32'd3781165056, 1248854016, 553543270, 170393600, 140509184, 155713536,
    81663099, 42226156, 24547164, 10402922, 5368709, 1692402,
    815687, 370986, 260571, 218104, 196608, 174273, 161586,
    142187, 129289, 111883, 100129, 91352, 84463, 74176, 66668,
    59633, 54264, 46630, 37550, 32286, 28846, 26445, 23331,
    21443, 18979, 17878};
  localparam logic [31:0] HeEnergyTab [HeLen] = '{
    134218, 201327, 268435, 402653, 536871, 671089,
    805306, 1073742, 1342177, 2013266, 2684355, 4026532, 5368709,
    6710886, 8053064, 10737418, 13421773, 20132659, 26843546,
    40265318, 53687091, 67108864, 80530637, 107374182, 134217728,
    167772160, 201326592, 268435456, 402653184, 536870912, 671088640,
    805306368, 1073741824, 1342177280, 2013265920, 32'd2684354560};
  localparam logic [31:0] HeAttenTab [HeLen] = '{
    63795364, 17574134, 7196377, 2104492, 978217, 604609, 439878,
    307547, 259627, 219362, 205521, 192728, 184864, 178572,
    173120, 163788, 155818, 140090, 128346, 111568, 99982,
    91300, 84452, 74197, 66710, 59643, 54243, 46368, 36732,
    30923, 27022, 24191, 20342, 17857, 14292, 12405};

  function automatic logic [31:0] energy_at(input logic [1:0] mat, input int i);
    return (mat == MatHe) ? HeEnergyTab[i] : StdEnergyTab[i];
  endfunction

  function automatic logic [31:0] atten_at(input logic [1:0] mat, input int i);
    return (mat == MatHe) ? HeAttenTab[i] : StdAttenTab[i];
  endfunction

  // Absorption coefficient for one wavelength under the given material.
  function automatic absorption_t absorption_of(input logic [1:0] mat,
                                                input logic [23:0] wl);
    absorption_t res;
    int          len;
    int          r;
    logic [63:0] scale;
    logic [63:0] energy;
    logic [63:0] e_left;
    logic [63:0] e_step;
    logic [63:0] dv;
    logic [63:0] interp;
    logic [63:0] coef;
    res.coefficient  = '0;
    res.out_of_range = 1'b1;
    case (mat)
      MatAir:  scale = 64'(ScaleAir);
      MatSi:   scale = 64'(ScaleSi);
      MatHe:   scale = 64'(ScaleHe);
      default: return res;
    endcase
    len = (mat == MatHe) ? HeLen : StdLen;
    if (wl == '0) return res;
    energy = 64'(EtwQ47) / 64'(wl);
    if (energy < 64'(energy_at(mat, 0)) || energy > 64'(energy_at(mat, len - 1)))
      return res;
    r = 0;
    while (r < len - 1 && 64'(energy_at(mat, r)) < energy) r++;
    if (r == 0) begin
      interp = 64'(atten_at(mat, 0));
    end else begin
      e_left = 64'(energy_at(mat, r - 1));
      e_step = 64'(energy_at(mat, r)) - e_left;
      dv     = energy - e_left;
      if (e_step == '0) begin
        interp = 64'(atten_at(mat, r - 1));
      end else begin
        interp = (64'(atten_at(mat, r)) * dv +
                  64'(atten_at(mat, r - 1)) * (e_step - dv)) / e_step;
      end
    end
    coef = (interp * scale + (64'd1 << 29)) >> 30;
    if (coef > 64'hFFFF_FFFF) coef = 64'hFFFF_FFFF;
    res.coefficient  = coef[31:0];
    res.out_of_range = 1'b0;
    return res;
  endfunction

  // Wavelength whose energy lands on (or just past) a table energy.
  function automatic logic [23:0] wl_for_energy(input logic [31:0] e);
    logic [63:0] q;
    q = 64'(EtwQ47) / 64'(e);
    if (q == '0) q = 64'd1;
    if (q > 64'hFF_FFFF) q = 64'hFF_FFFF;
    return q[23:0];
  endfunction

  // Receiver: stall at the chosen rate, check each accepted result.
  always @(posedge clk) begin
    absorption_t want;
    if (rst) begin
      ready_out <= 1'b0;
    end else begin
      ready_out <= ($urandom_range(99) >= receiver_stall_pct);
      if (valid_out && ready_out) begin
        if (pending_absorption.size() == 0) begin
          $error("unexpected result: coefficient=%0d out_of_range=%0b",
                 coefficient, out_of_range);
          failed = 1'b1;
        end else begin
          want = pending_absorption.pop_front();
          if (coefficient !== want.coefficient) begin
            $error("coefficient: expected %0d, got %0d", want.coefficient, coefficient);
            failed = 1'b1;
          end
          if (out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %0b, got %0b",
                   want.out_of_range, out_of_range);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on either channel.
  always @(posedge clk) begin
    if (rst || (valid_in && ready_in) || (valid_out && ready_out)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Drop valid once the last item has gone, unless it is already low.
  task automatic release_input();
    if (driving_in) begin
      valid_in   <= 1'b0;
      driving_in = 1'b0;
    end
  endtask

  // Present one item, hold it until accepted, queue its expectation.
  task automatic send_wavelength(input logic [23:0] wl, input logic use_lit,
                                 input absorption_t lit);
    while ($urandom_range(99) < sender_idle_pct) begin
      release_input();
      @(posedge clk);
    end
    valid_in   <= 1'b1;
    wavelength <= wl;
    driving_in = 1'b1;
    pending_absorption.push_back(use_lit ? lit : absorption_of(material, wl));
    @(posedge clk);
    while (!ready_in) @(posedge clk);
  endtask

  // Drain everything, let the block settle, then write the register.
  task automatic set_material(input logic [1:0] mat);
    release_input();
    while (pending_absorption.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= mat;
    @(posedge clk);
    cfg_we   <= 1'b0;
    material = mat;
  endtask

  task automatic send_random(input int count);
    logic [23:0] wl;
    int          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        // Inside the table: roughly 0.005 to 0.09 angstrom.
        wl = 24'($urandom_range(24'h01_7000, 24'h00_1400));
      end else if (pick < 70) begin
        // Near a table energy.
        wl = wl_for_energy(energy_at(material, $urandom_range(StdLen - 3)));
        wl = wl + 24'($urandom_range(4)) - 24'd2;
      end else if (pick < 95) begin
        wl = 24'($urandom);
      end else begin
        wl = 24'($urandom_range(3));
      end
      send_wavelength(wl, 1'b0, '0);
    end
  endtask

  directed_row_t directed[$];

  initial begin
    directed_row_t row;
    logic [1:0]    mat_order[4];
    rst                = 1'b1;
    valid_in           = 1'b0;
    driving_in         = 1'b0;
    wavelength         = '0;
    cfg_we             = 1'b0;
    cfg_data           = '0;
    failed             = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    material           = MatAir;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows for air after reset: zero wavelength, field extremes,
    // table ends, first entry exact, duplicate energy, interior points.
    directed.push_back('{24'd0, 1'b1, '{32'd0, 1'b1}});
    directed.push_back('{24'hFF_FFFF, 1'b1, '{32'd0, 1'b1}});
    directed.push_back('{24'd1, 1'b1, '{32'd0, 1'b1}});
    directed.push_back('{24'hAA_AAAA, 1'b0, '0});
    directed.push_back('{24'h55_5555, 1'b0, '0});
    directed.push_back('{wl_for_energy(StdEnergyTab[0]), 1'b0, '0});
    directed.push_back('{wl_for_energy(StdEnergyTab[0]) + 24'd1, 1'b1, '{32'd0, 1'b1}});
    directed.push_back('{wl_for_energy(StdEnergyTab[StdLen - 1]), 1'b0, '0});
    directed.push_back('{wl_for_energy(StdEnergyTab[StdLen - 1]) - 24'd1, 1'b1,
                         '{32'd0, 1'b1}});
    directed.push_back('{wl_for_energy(StdEnergyTab[4]), 1'b0, '0});
    directed.push_back('{wl_for_energy(StdEnergyTab[4]) + 24'd1, 1'b0, '0});
    directed.push_back('{24'h00_1000, 1'b0, '0});
    directed.push_back('{24'h01_0000, 1'b0, '0});
    directed.push_back('{24'h00_4000, 1'b0, '0});
    foreach (directed[i]) begin
      row = directed[i];
      send_wavelength(row.wl, row.check_lit, row.lit);
    end

    // Silicon at the steep low-energy end, then the unused code and helium.
    set_material(MatSi);
    send_wavelength(wl_for_energy(StdEnergyTab[0]), 1'b0, '0);
    send_wavelength(wl_for_energy(StdEnergyTab[1]) + 24'd3, 1'b0, '0);
    send_wavelength(24'h00_2000, 1'b0, '0);
    set_material(MatNone);
    send_wavelength(24'h00_2000, 1'b1, '{32'd0, 1'b1});
    send_wavelength(24'h80_0000, 1'b1, '{32'd0, 1'b1});
    set_material(MatHe);
    send_wavelength(wl_for_energy(HeEnergyTab[0]), 1'b0, '0);
    send_wavelength(wl_for_energy(HeEnergyTab[HeLen - 1]), 1'b0, '0);
    send_wavelength(24'h00_2000, 1'b0, '0);

    // Random part: every idle profile under every material.
    mat_order = '{MatAir, MatSi, MatHe, MatNone};
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 45; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 45; end
        default: begin sender_idle_pct = 13; receiver_stall_pct = 13; end
      endcase
      for (int m = 0; m < 4; m++) begin
        set_material(mat_order[(m + ph) % 4]);
        send_random((mat_order[(m + ph) % 4] == MatNone) ? 25 : 125);
        // Hold the sender until the pipeline is empty.
        if (m == 1) begin
          release_input();
          while (pending_absorption.size() != 0) @(posedge clk);
        end
      end
    end

    release_input();
    while (pending_absorption.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (!failed) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
